// ----- design/mks_pkg.sv -----
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants of the keypad scanner
// Scan phase codes, register indexes, field widths and the row drive table.
// ----------------------------------------------------------------------------
package mks_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam int TICKS_W     = 16;
  localparam int COLS_W      = 2;
  localparam int ROWS_W      = 3;
  localparam int KEYS_W      = 6;
  localparam int PHASE_W     = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int RES_W       = ROWS_W + KEYS_W + PHASE_W;
  localparam int OUT_TDATA_W = 16;

  localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RESET = 16'd20;
  localparam logic               WAIT_RELEASE_RESET   = 1'b1;

  // Configuration register indexes.
  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_WAIT_RELEASE   = 1'b1;

  localparam logic [COLS_W-1:0] COLS_RELEASED = 2'b11;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_ROW1     = 3'd2,
    PH_ROW2     = 3'd3,
    PH_ROW3     = 3'd4,
    PH_RELEASE  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [PHASE_W-1:0] scan_phase;
    logic [KEYS_W-1:0]  key_flags;
    logic [ROWS_W-1:0]  row_drive;
  } result_t;

  // Active-low row drive: only the row being scanned is pulled low; all rows low
  // otherwise so that any press shows on the columns.
  function automatic logic [ROWS_W-1:0] drive_for(phase_t ph);
    logic [ROWS_W-1:0] drv;
    case (ph)
      PH_ROW1: drv = 3'b110;
      PH_ROW2: drv = 3'b101;
      PH_ROW3: drv = 3'b011;
      default: drv = 3'b000;
    endcase
    return drv;
  endfunction

endpackage

// ----- design/matrix_keypad_scanner.sv -----
// ----------------------------------------------------------------------------
// matrix_keypad_scanner: debounced scanner for a 3-row by 2-column keypad
// Each input item is one tick carrying the sampled active-low column levels,
// and each tick yields exactly one result item with the row drive to apply,
// the latched key flags and the scan phase after that tick. The state update
// is a single registered step, so an item is taken in every clock cycle unless
// the skid stage is occupied; the result register and a one-entry skid stage
// let the input keep flowing for one item while the output is stalled, and
// each result is registered before it leaves. debounce_ticks sets how many
// ticks pass between the first sight of a press and its confirmation; with
// wait_release set the block holds all rows low after a scan until both
// columns read high again. Configuration is to be written by the user through
// the plain write port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner #(
  parameter int COUNT_WIDTH = mks_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [mks_pkg::TICKS_W-1:0]      cfg_data,
  // Input stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mks_pkg::IN_TDATA_W-1:0]   s_tdata,  // [1:0] column_levels
  // Output stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mks_pkg::OUT_TDATA_W-1:0]  m_tdata   // [2:0] row_drive, [8:3] key_flags,
                                                     // [11:9] scan_phase
);

  localparam int CmpW = (COUNT_WIDTH > mks_pkg::TICKS_W) ? COUNT_WIDTH : mks_pkg::TICKS_W;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  // Configuration registers.
  logic [mks_pkg::TICKS_W-1:0] debounce_ticks;
  logic                        wait_release;

  // Scan state.
  mks_pkg::phase_t             phase, phase_next;
  logic [COUNT_WIDTH-1:0]      debounce_count, debounce_count_next;
  logic [mks_pkg::KEYS_W-1:0]  keys_latched, keys_latched_next;

  // Output register and skid stage.
  mks_pkg::result_t            out_data, skid_data, result;
  logic                        out_valid, skid_valid;

  logic [mks_pkg::COLS_W-1:0]  cols;
  logic [mks_pkg::COLS_W-1:0]  pressed;
  logic                        any_key;
  logic [CmpW-1:0]             ticks_ext;
  logic [COUNT_WIDTH-1:0]      target;
  logic                        accept;

  assign cols    = s_tdata[mks_pkg::COLS_W-1:0];
  assign pressed = ~cols;
  assign any_key = (cols != mks_pkg::COLS_RELEASED);
  assign accept  = s_tvalid && s_tready;

  // The debounce target saturates at the largest count the counter can hold.
  assign ticks_ext = CmpW'(debounce_ticks);
  assign target    = (ticks_ext > CmpW'(CountMax)) ? CountMax
                                                   : ticks_ext[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= mks_pkg::DEBOUNCE_TICKS_RESET;
      wait_release   <= mks_pkg::WAIT_RELEASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mks_pkg::REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        mks_pkg::REG_WAIT_RELEASE:   wait_release   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_next          = phase;
    debounce_count_next = debounce_count;
    keys_latched_next   = keys_latched;
    case (phase)
      mks_pkg::PH_DEBOUNCE: begin
        if (debounce_count < target) begin
          debounce_count_next = debounce_count + COUNT_WIDTH'(1);
        end else if (any_key) begin
          phase_next = mks_pkg::PH_ROW1;
        end else begin
          keys_latched_next = '0;
          phase_next        = mks_pkg::PH_IDLE;
        end
      end
      mks_pkg::PH_ROW1: begin
        keys_latched_next[1:0] = pressed;
        phase_next             = mks_pkg::PH_ROW2;
      end
      mks_pkg::PH_ROW2: begin
        keys_latched_next[3:2] = pressed;
        phase_next             = mks_pkg::PH_ROW3;
      end
      mks_pkg::PH_ROW3: begin
        keys_latched_next[5:4] = pressed;
        phase_next = wait_release ? mks_pkg::PH_RELEASE : mks_pkg::PH_IDLE;
      end
      mks_pkg::PH_RELEASE: begin
        if (!any_key) begin
          phase_next = mks_pkg::PH_IDLE;
        end
      end
      default: begin
        if (any_key) begin
          phase_next          = mks_pkg::PH_DEBOUNCE;
          debounce_count_next = '0;
        end else begin
          keys_latched_next = '0;
          phase_next        = mks_pkg::PH_IDLE;
        end
      end
    endcase
  end

  // Result of this tick, taken from the state it leaves behind.
  always_comb begin
    result.row_drive  = mks_pkg::drive_for(phase_next);
    result.key_flags  = keys_latched_next;
    result.scan_phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mks_pkg::PH_IDLE;
      debounce_count <= '0;
      keys_latched   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      debounce_count <= debounce_count_next;
      keys_latched   <= keys_latched_next;
    end
  end

  // The skid stage catches one item while the output register is stalled;
  // input is held off only while the skid stage is occupied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (accept) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end else if (accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = mks_pkg::OUT_TDATA_W'(out_data);

endmodule
